FILE: rtl/core/asw_pkg.sv
package asw_pkg;

  // Command codes carried in the input transaction.
  localparam logic [2:0] CMD_ENABLE  = 3'd0;
  localparam logic [2:0] CMD_DISABLE = 3'd1;
  localparam logic [2:0] CMD_START   = 3'd2;
  localparam logic [2:0] CMD_STOP    = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;

  // Status codes returned with every result transaction.
  localparam logic [3:0] ST_ENABLED          = 4'd0;
  localparam logic [3:0] ST_ALREADY_ENABLED  = 4'd1;
  localparam logic [3:0] ST_DISABLED         = 4'd2;
  localparam logic [3:0] ST_ALREADY_DISABLED = 4'd3;
  localparam logic [3:0] ST_NOT_ENABLED      = 4'd4;
  localparam logic [3:0] ST_ALREADY_STARTED  = 4'd5;
  localparam logic [3:0] ST_STARTED          = 4'd6;
  localparam logic [3:0] ST_ALREADY_STOPPED  = 4'd7;
  localparam logic [3:0] ST_STOPPED          = 4'd8;
  localparam logic [3:0] ST_RUNNING          = 4'd9;
  localparam logic [3:0] ST_TOTAL            = 4'd10;
  localparam logic [3:0] ST_UNKNOWN          = 4'd11;

  // Nanoseconds per second, one bit wider than a nanosecond field.
  localparam logic [30:0] NS_PER_SEC = 31'd1000000000;
  // Largest legal nanosecond value.
  localparam logic [29:0] NS_MAX     = 30'd999999999;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  timer_index;
    logic [31:0] now_seconds;
    logic [29:0] now_nanoseconds;
  } in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] total_seconds;
    logic [29:0] total_nanoseconds;
  } out_t;

  // Update and read controls from the command decoder to the timer storage.
  typedef struct packed {
    logic [3:0] status;
    logic       en_set;
    logic       en_clr;
    logic       run_set;
    logic       run_clr;
    logic       start_wr;
    logic       accum_clr;
    logic       accum_wr;
    logic       total_rd;
  } ctl_t;

endpackage

FILE: rtl/core/asw_cmd.sv
module asw_cmd
  import asw_pkg::*;
(
  input  logic [2:0] command,
  input  logic       idx_ok,
  input  logic       enabled,
  input  logic       running,
  output ctl_t       ctl
);

  // Decode the command against the addressed timer's flags.
  always_comb begin
    ctl        = '0;
    ctl.status = ST_UNKNOWN;
    if (idx_ok) begin
      unique case (command)
        CMD_ENABLE: begin
          if (enabled) begin
            ctl.status = ST_ALREADY_ENABLED;
          end else begin
            ctl.status    = ST_ENABLED;
            ctl.en_set    = 1'b1;
            ctl.accum_clr = 1'b1;
          end
        end
        CMD_DISABLE: begin
          if (enabled) begin
            ctl.status = ST_DISABLED;
            ctl.en_clr = 1'b1;
          end else begin
            ctl.status = ST_ALREADY_DISABLED;
          end
        end
        CMD_START: begin
          if (!enabled) begin
            ctl.status = ST_NOT_ENABLED;
          end else if (running) begin
            ctl.status = ST_ALREADY_STARTED;
          end else begin
            ctl.status   = ST_STARTED;
            ctl.run_set  = 1'b1;
            ctl.start_wr = 1'b1;
          end
        end
        CMD_STOP: begin
          if (!enabled) begin
            ctl.status = ST_NOT_ENABLED;
          end else if (!running) begin
            ctl.status = ST_ALREADY_STOPPED;
          end else begin
            ctl.status   = ST_STOPPED;
            ctl.run_clr  = 1'b1;
            ctl.accum_wr = 1'b1;
          end
        end
        CMD_READ: begin
          if (!enabled) begin
            ctl.status = ST_NOT_ENABLED;
          end else if (running) begin
            ctl.status = ST_RUNNING;
          end else begin
            ctl.status   = ST_TOTAL;
            ctl.total_rd = 1'b1;
          end
        end
        default: begin
          ctl.status = ST_UNKNOWN;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/asw_accum.sv
module asw_accum
  import asw_pkg::*;
(
  input  logic [31:0] now_s,
  input  logic [29:0] now_ns,
  input  logic [31:0] start_s,
  input  logic [29:0] start_ns,
  input  logic [31:0] acc_s,
  input  logic [29:0] acc_ns,
  output logic [31:0] sum_s,
  output logic [29:0] sum_ns
);

  logic        borrow;
  logic [30:0] diff_ns;
  logic [30:0] d_ns;
  logic [31:0] d_s;
  logic [30:0] add_ns;
  logic        carry;
  logic [30:0] fix_ns;

  // Elapsed time since start, borrowing one second when the nanoseconds underflow.
  always_comb begin
    borrow  = now_ns < start_ns;
    diff_ns = {1'b0, now_ns} - {1'b0, start_ns};
    d_ns    = borrow ? (diff_ns + NS_PER_SEC) : diff_ns;
    d_s     = now_s - start_s - {31'd0, borrow};
  end

  // Add the elapsed time to the total, carrying a whole second when due.
  always_comb begin
    add_ns = {1'b0, acc_ns} + d_ns;
    carry  = add_ns >= NS_PER_SEC;
    fix_ns = carry ? (add_ns - NS_PER_SEC) : add_ns;
    sum_ns = fix_ns[29:0];
    sum_s  = acc_s + d_s + {31'd0, carry};
  end

endmodule

FILE: rtl/core/accumulating_stopwatch_bank.sv
// A command's result passes from the input register to the result register, where it is
// offered on the output; a stalled output can hold the command in the input register.
// Throughput: one command per cycle while the output is not stalled; the timer state is
// read, updated and written back between the input register and the result register.
// Reset: rst_n is synchronous and active low; it clears the valid bits and every timer's
// enable and running flags. Start times and totals are written before they are used.
module accumulating_stopwatch_bank
  import asw_pkg::*;
#(
  parameter int TIMER_COUNT = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam logic [5:0] TIMER_COUNT_6 = 6'(TIMER_COUNT);

  logic                   stage_vld_r;
  logic                   stage_vld_nxt;
  in_t                    stage_r;
  in_t                    stage_nxt;
  logic                   out_vld_r;
  logic                   out_vld_nxt;
  out_t                   out_r;
  out_t                   out_nxt;
  logic [TIMER_COUNT-1:0] en_flags_r;
  logic [TIMER_COUNT-1:0] en_flags_nxt;
  logic [TIMER_COUNT-1:0] run_flags_r;
  logic [TIMER_COUNT-1:0] run_flags_nxt;
  logic [31:0]            start_s_r [TIMER_COUNT];
  logic [29:0]            start_ns_r [TIMER_COUNT];
  logic [31:0]            acc_s_r [TIMER_COUNT];
  logic [29:0]            acc_ns_r [TIMER_COUNT];

  logic                   out_free;
  logic                   stage_fire;
  logic                   in_acc;
  logic [5:0]             idx_ext;
  logic                   idx_ok;
  logic [IDX_W-1:0]       tidx;
  logic [29:0]            now_ns_clamped;
  ctl_t                   ctl;
  logic [31:0]            sum_s;
  logic [29:0]            sum_ns;

  // Handshake: the output register frees when empty or taken.
  assign out_free   = !out_vld_r || !out_stall;
  assign stage_fire = stage_vld_r && out_free;
  assign in_stall   = stage_vld_r && !out_free;
  assign in_acc     = in_valid && !in_stall;
  assign out_valid  = out_vld_r;
  assign out_data   = out_r;

  // Out-of-range nanoseconds are pinned to the last legal value on entry.
  assign now_ns_clamped = (in_data.now_nanoseconds > NS_MAX) ? NS_MAX
                                                             : in_data.now_nanoseconds;

  // Input register contents with the nanoseconds already pinned.
  always_comb begin
    stage_nxt                 = in_data;
    stage_nxt.now_nanoseconds = now_ns_clamped;
  end

  // Timer selection.
  assign idx_ext = {3'b000, stage_r.timer_index};
  assign idx_ok  = idx_ext < TIMER_COUNT_6;
  assign tidx    = IDX_W'(idx_ext);

  asw_cmd u_cmd (
    .command (stage_r.command),
    .idx_ok  (idx_ok),
    .enabled (idx_ok && en_flags_r[tidx]),
    .running (idx_ok && run_flags_r[tidx]),
    .ctl     (ctl)
  );

  asw_accum u_accum (
    .now_s    (stage_r.now_seconds),
    .now_ns   (stage_r.now_nanoseconds),
    .start_s  (start_s_r[tidx]),
    .start_ns (start_ns_r[tidx]),
    .acc_s    (acc_s_r[tidx]),
    .acc_ns   (acc_ns_r[tidx]),
    .sum_s    (sum_s),
    .sum_ns   (sum_ns)
  );

  // Next values of the pipeline valid bits and the flag vectors.
  always_comb begin
    stage_vld_nxt = stage_vld_r;
    if (in_acc) begin
      stage_vld_nxt = 1'b1;
    end else if (stage_fire) begin
      stage_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_free ? stage_vld_r : out_vld_r;

    en_flags_nxt  = en_flags_r;
    run_flags_nxt = run_flags_r;
    if (stage_fire) begin
      if (ctl.en_set) begin
        en_flags_nxt[tidx] = 1'b1;
      end
      if (ctl.en_clr) begin
        en_flags_nxt[tidx] = 1'b0;
      end
      if (ctl.run_set) begin
        run_flags_nxt[tidx] = 1'b1;
      end
      if (ctl.run_clr) begin
        run_flags_nxt[tidx] = 1'b0;
      end
    end
  end

  // Result of the command in the input register.
  always_comb begin
    out_nxt                   = '0;
    out_nxt.status            = ctl.status;
    if (ctl.total_rd) begin
      out_nxt.total_seconds     = acc_s_r[tidx];
      out_nxt.total_nanoseconds = acc_ns_r[tidx];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
      out_vld_r   <= 1'b0;
      en_flags_r  <= '0;
      run_flags_r <= '0;
    end else begin
      stage_vld_r <= stage_vld_nxt;
      out_vld_r   <= out_vld_nxt;
      en_flags_r  <= en_flags_nxt;
      run_flags_r <= run_flags_nxt;
    end
  end

  // Payload registers and per-timer times.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      stage_r <= stage_nxt;
    end
    if (stage_fire) begin
      out_r <= out_nxt;
      if (ctl.start_wr) begin
        start_s_r[tidx]  <= stage_r.now_seconds;
        start_ns_r[tidx] <= stage_r.now_nanoseconds;
      end
      if (ctl.accum_clr) begin
        acc_s_r[tidx]  <= '0;
        acc_ns_r[tidx] <= '0;
      end else if (ctl.accum_wr) begin
        acc_s_r[tidx]  <= sum_s;
        acc_ns_r[tidx] <= sum_ns;
      end
    end
  end

`ifndef SYNTHESIS
  // An unknown command or timer leaves every flag as it was.
  a_unknown_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_fire && ctl.status == ST_UNKNOWN)
      |=> ($stable(en_flags_r) && $stable(run_flags_r)))
    else $error("flags changed on an unknown command or timer");

  // Totals are returned only with the total status.
  a_total_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.status != ST_TOTAL)
      |-> (out_r.total_seconds == '0 && out_r.total_nanoseconds == '0))
    else $error("nonzero total without total status");

  // A successful start leaves the timer running.
  a_start_sets_running: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_fire && ctl.run_set) |=> run_flags_r[$past(tidx)])
    else $error("running flag not set after start");

  // A held command in the input register does not change.
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_vld_r && !out_free) |=> (stage_vld_r && $stable(stage_r)))
    else $error("input register changed while blocked");
`endif

endmodule
